### hdl/spp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, constants and helpers of the skinning matrix palette.
// ----------------------------------------------------------------------------
package spp_pkg;

   localparam int MAX_BONES_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_LANES     = 4;
   localparam int NUM_PAIRS     = 8;

   typedef enum logic [1:0] {
      REQ_LOAD_REST = 2'd0,
      REQ_LOAD_OFF  = 2'd1,
      REQ_POSE      = 2'd2,
      REQ_POSE_REST = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_REST_RD,
      ST_PAR_RD,
      ST_PAR_CHK,
      ST_GLB_RD,
      ST_MUL_GLB,
      ST_COPY,
      ST_OFF,
      ST_MUL_RES,
      ST_EMIT
   } state_type;

   // pair p holds element 2p in bits 31..0 and element 2p+1 in bits 63..32
   typedef logic [NUM_PAIRS-1:0][63:0] mat_type;

   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [1:0] row;
   } lane_ctl_type;

   function automatic logic signed [31:0] mat_elem(mat_type m, logic [1:0] r, logic [1:0] c);
      logic [63:0] p;
      p = m[{r, c[1]}];
      return c[0] ? p[63:32] : p[31:0];
   endfunction

endpackage

### hdl/spp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spp_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hdl/spp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_lane
// One result column: multiply, floor-shift and accumulate over the k terms.
// ----------------------------------------------------------------------------
module spp_lane #(
   parameter int FRAC_BITS = 16,
   parameter int ACC_W     = 50
) (
   input  logic                       clock,
   input  logic                       reset,
   input  spp_pkg::lane_ctl_type      ctl_in,
   input  logic signed [31:0]         op_a,
   input  logic signed [31:0]         op_b,
   output spp_pkg::lane_ctl_type      ctl_out,
   output logic signed [ACC_W-1:0]    acc_out
);
   import spp_pkg::*;

   logic signed [63:0]      prod_ff;
   lane_ctl_type            c1_ff;
   lane_ctl_type            c2_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [63:0]      shifted;
   logic signed [ACC_W-1:0] acc_in;

   assign shifted = prod_ff >>> FRAC_BITS;
   assign acc_in  = (c1_ff.first ? '0 : acc_ff) + ACC_W'(shifted);

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
      end else begin
         c1_ff <= ctl_in;
         c2_ff <= c1_ff;
      end
      prod_ff <= op_a * op_b;
      if (c1_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign ctl_out = c2_ff;
   assign acc_out = acc_ff;

endmodule

### hdl/spp_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_merge
// Saturate the lane sums to 32 bits and pack them as one result row.
// ----------------------------------------------------------------------------
module spp_merge #(
   parameter int ACC_W = 50
) (
   input  spp_pkg::lane_ctl_type                          ctl_in,
   input  logic signed [spp_pkg::NUM_LANES-1:0][ACC_W-1:0] acc_in,
   output spp_pkg::lane_ctl_type                          row_ctl,
   output logic [1:0][63:0]                               row_pairs
);
   import spp_pkg::*;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   logic [NUM_LANES-1:0][31:0] sat;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         if ($signed(acc_in[i]) > SAT_HI) begin
            sat[i] = 32'h7FFF_FFFF;
         end else if ($signed(acc_in[i]) < SAT_LO) begin
            sat[i] = 32'h8000_0000;
         end else begin
            sat[i] = acc_in[i][31:0];
         end
      end
   end

   assign row_ctl   = ctl_in;
   assign row_pairs = {sat[3], sat[2], sat[1], sat[0]};

endmodule

### hdl/skeleton_pose_palette_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_pose_palette_top
// Skinning matrix palette: stores rest, offset and global matrices per bone
// and emits global * offset for every posed bone.
// ----------------------------------------------------------------------------
// Items are taken one at a time. After reset the parent table is swept to
// "no parent" with req_stall high. A load item makes eight 64-bit RAM writes.
// A pose item runs one 4x4 product without a parent and two with one, after
// reading back the stored rest matrix when it uses it: each 4x4 product runs
// on four column lanes, one multiply per lane per cycle, 16 steps through the
// product and accumulator registers, and each matrix moves through its RAM
// port one 64-bit pair per cycle with a registered read. The result is
// held in an output register until taken; the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module skeleton_pose_palette_top #(
   parameter int MAX_BONES = spp_pkg::MAX_BONES_DEF,
   parameter int FRAC_BITS = spp_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_bone_index,
   input  logic [6:0]  req_parent_index,
   input  logic [63:0] req_mat_pair_0,
   input  logic [63:0] req_mat_pair_1,
   input  logic [63:0] req_mat_pair_2,
   input  logic [63:0] req_mat_pair_3,
   input  logic [63:0] req_mat_pair_4,
   input  logic [63:0] req_mat_pair_5,
   input  logic [63:0] req_mat_pair_6,
   input  logic [63:0] req_mat_pair_7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_out_bone,
   output logic [63:0] rsp_out_pair_0,
   output logic [63:0] rsp_out_pair_1,
   output logic [63:0] rsp_out_pair_2,
   output logic [63:0] rsp_out_pair_3,
   output logic [63:0] rsp_out_pair_4,
   output logic [63:0] rsp_out_pair_5,
   output logic [63:0] rsp_out_pair_6,
   output logic [63:0] rsp_out_pair_7
);
   import spp_pkg::*;

   localparam int BI_W   = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int ADDR_W = BI_W + 3;
   localparam int ACC_W  = 66 - FRAC_BITS;

   state_type    state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [BI_W-1:0] clr_ff, clr_in;
   logic [3:0]   step_ff, step_in;
   logic         mul_run_ff, mul_run_in;

   req_kind_type kind_ff;
   logic [5:0]   bone_ff;
   logic [6:0]   par_in_ff;
   logic [BI_W-1:0] par_ff;
   mat_type      a_ff, b_ff, c_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [5:0]   out_bone_ff;
   mat_type      out_mat_ff;

   logic         accept, bone_ok, par_ok, out_free, mul_start, mul_done;
   logic [BI_W-1:0] bone_idx;
   logic [2:0]   word, fill;

   logic         rest_we, off_we, glb_we, pt_we;
   logic [ADDR_W-1:0] rest_ra, off_ra, glb_ra, glb_wa, mat_wa;
   logic [63:0]  rest_rd, off_rd, glb_rd;
   logic [BI_W-1:0] pt_wa, pt_ra;
   logic [6:0]   pt_wd, pt_rd;

   lane_ctl_type issue_ctl, row_ctl;
   lane_ctl_type [NUM_LANES-1:0] lane_ctl;
   logic signed [NUM_LANES-1:0][ACC_W-1:0] lane_acc;
   logic [1:0][63:0] row_pairs;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign bone_ok   = (32'(req_bone_index) < MAX_BONES);
   assign bone_idx  = BI_W'(bone_ff);
   assign word      = cnt_ff[2:0];
   assign fill      = 3'(cnt_ff - 4'd1);
   assign par_ok    = !pt_rd[6] && (32'(pt_rd) < MAX_BONES);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mat_wa    = {bone_idx, word};
   assign mul_done  = row_ctl.valid && row_ctl.last && (row_ctl.row == 2'd3);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (32'(clr_ff) == MAX_BONES - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && bone_ok) begin
               case (req_kind_type'(req_type))
                  REQ_LOAD_REST, REQ_LOAD_OFF: state_in = ST_LOAD;
                  REQ_POSE:                    state_in = ST_PAR_RD;
                  default:                     state_in = ST_REST_RD;
               endcase
            end
         end
         ST_LOAD:    if (cnt_ff == 4'd7) state_in = ST_IDLE;
         ST_REST_RD: if (cnt_ff == 4'd8) state_in = ST_PAR_RD;
         ST_PAR_RD:  state_in = ST_PAR_CHK;
         ST_PAR_CHK: state_in = par_ok ? ST_GLB_RD : ST_COPY;
         ST_GLB_RD:  if (cnt_ff == 4'd8) state_in = ST_MUL_GLB;
         ST_MUL_GLB: if (mul_done) state_in = ST_OFF;
         ST_COPY:    state_in = ST_OFF;
         ST_OFF:     if (cnt_ff == 4'd8) state_in = ST_MUL_RES;
         ST_MUL_RES: if (mul_done) state_in = ST_EMIT;
         ST_EMIT:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      rest_we   = 1'b0;
      off_we    = 1'b0;
      glb_we    = 1'b0;
      pt_we     = 1'b0;
      pt_wa     = bone_idx;
      pt_wd     = par_in_ff;
      pt_ra     = bone_idx;
      rest_ra   = mat_wa;
      off_ra    = mat_wa;
      glb_ra    = {par_ff, word};
      glb_wa    = mat_wa;
      mul_start = 1'b0;
      cnt_in    = 4'd0;
      clr_in    = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            pt_we  = 1'b1;
            pt_wa  = clr_ff;
            pt_wd  = 7'h7F;
            clr_in = clr_ff + BI_W'(1);
         end
         ST_LOAD: begin
            rest_we = (kind_ff == REQ_LOAD_REST);
            off_we  = (kind_ff == REQ_LOAD_OFF);
            pt_we   = (kind_ff == REQ_LOAD_OFF) && (cnt_ff == 4'd0);
            cnt_in  = cnt_ff + 4'd1;
         end
         ST_REST_RD, ST_GLB_RD: begin
            cnt_in    = (cnt_ff == 4'd8) ? 4'd0 : cnt_ff + 4'd1;
            mul_start = (state_ff == ST_GLB_RD) && (cnt_ff == 4'd8);
         end
         ST_OFF: begin
            glb_we    = !cnt_ff[3];
            cnt_in    = (cnt_ff == 4'd8) ? 4'd0 : cnt_ff + 4'd1;
            mul_start = (cnt_ff == 4'd8);
         end
         default: begin
            cnt_in = 4'd0;
         end
      endcase
   end

   // lane issue
   assign mul_run_in = mul_start || (mul_run_ff && step_ff != 4'hF);
   assign step_in    = mul_run_ff ? step_ff + 4'd1 : 4'd0;
   assign issue_ctl  = '{valid: mul_run_ff, first: (step_ff[1:0] == 2'd0),
                         last: (step_ff[1:0] == 2'd3), row: step_ff[3:2]};

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      spp_lane #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (issue_ctl),
         .op_a    (mat_elem(a_ff, step_ff[3:2], step_ff[1:0])),
         .op_b    (mat_elem(b_ff, step_ff[1:0], 2'(g))),
         .ctl_out (lane_ctl[g]),
         .acc_out (lane_acc[g])
      );
   end

   spp_merge #(.ACC_W(ACC_W)) u_merge (
      .ctl_in    (lane_ctl[0]),
      .acc_in    (lane_acc),
      .row_ctl   (row_ctl),
      .row_pairs (row_pairs)
   );

   spp_ram #(.WIDTH(64), .DEPTH(MAX_BONES * 8), .ADDR_W(ADDR_W)) u_rest_ram (
      .clock(clock), .wr_en(rest_we), .wr_addr(mat_wa), .wr_data(b_ff[word]),
      .rd_addr(rest_ra), .rd_data(rest_rd)
   );

   spp_ram #(.WIDTH(64), .DEPTH(MAX_BONES * 8), .ADDR_W(ADDR_W)) u_off_ram (
      .clock(clock), .wr_en(off_we), .wr_addr(mat_wa), .wr_data(b_ff[word]),
      .rd_addr(off_ra), .rd_data(off_rd)
   );

   spp_ram #(.WIDTH(64), .DEPTH(MAX_BONES * 8), .ADDR_W(ADDR_W)) u_glb_ram (
      .clock(clock), .wr_en(glb_we), .wr_addr(glb_wa), .wr_data(c_ff[word]),
      .rd_addr(glb_ra), .rd_data(glb_rd)
   );

   spp_ram #(.WIDTH(7), .DEPTH(MAX_BONES), .ADDR_W(BI_W)) u_par_ram (
      .clock(clock), .wr_en(pt_we), .wr_addr(pt_wa), .wr_data(pt_wd),
      .rd_addr(pt_ra), .rd_data(pt_rd)
   );

   assign rsp_valid_in = (state_ff == ST_EMIT && out_free) ? 1'b1 :
                         (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= 4'd0;
         clr_ff       <= '0;
         step_ff      <= 4'd0;
         mul_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         mul_run_ff   <= mul_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind_type'(req_type);
         bone_ff   <= req_bone_index;
         par_in_ff <= req_parent_index;
         b_ff      <= {req_mat_pair_7, req_mat_pair_6, req_mat_pair_5, req_mat_pair_4,
                       req_mat_pair_3, req_mat_pair_2, req_mat_pair_1, req_mat_pair_0};
      end
      if (state_ff == ST_REST_RD && cnt_ff != 4'd0) b_ff[fill] <= rest_rd;
      if (state_ff == ST_OFF && cnt_ff != 4'd0) b_ff[fill] <= off_rd;
      if (state_ff == ST_GLB_RD && cnt_ff != 4'd0) a_ff[fill] <= glb_rd;
      if (state_ff == ST_OFF && cnt_ff == 4'd0) a_ff <= c_ff;
      if (state_ff == ST_PAR_CHK) par_ff <= BI_W'(pt_rd);
      if (state_ff == ST_COPY) c_ff <= b_ff;
      if (row_ctl.valid && row_ctl.last) begin
         c_ff[{row_ctl.row, 1'b0}] <= row_pairs[0];
         c_ff[{row_ctl.row, 1'b1}] <= row_pairs[1];
      end
      if (state_ff == ST_EMIT && out_free) begin
         out_bone_ff <= bone_ff;
         out_mat_ff  <= c_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_bone   = out_bone_ff;
   assign rsp_out_pair_0 = out_mat_ff[0];
   assign rsp_out_pair_1 = out_mat_ff[1];
   assign rsp_out_pair_2 = out_mat_ff[2];
   assign rsp_out_pair_3 = out_mat_ff[3];
   assign rsp_out_pair_4 = out_mat_ff[4];
   assign rsp_out_pair_5 = out_mat_ff[5];
   assign rsp_out_pair_6 = out_mat_ff[6];
   assign rsp_out_pair_7 = out_mat_ff[7];

   a_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_GLB || state_ff == ST_MUL_RES))
      else $error("product finished outside a multiply state");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised without an emit");

   a_row_from_issue: assert property (@(posedge clock) disable iff (reset)
      row_ctl.valid |-> $past(mul_run_ff, 2))
      else $error("merged row without a lane issue");

   a_no_issue_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mul_run_ff)
      else $error("lanes running while idle");

endmodule

### dv/tb_skeleton_pose_palette_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_skeleton_pose_palette_top
// Self-checking bench for the skinning matrix palette.
// ----------------------------------------------------------------------------
// Loads rest and offset matrices for random bone chains, then poses them
// frame by frame in parent-first order. A scoreboard keeps its own copy of
// the bone stores, predicts global * offset in Q16.16 with floor shifts and
// saturation, and checks every result transfer in order. Both sides idle at
// random; once the result side holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_skeleton_pose_palette_top;
   import spp_pkg::*;

   localparam int ITEM_TARGET = 1350;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      req_kind_type       kind;
      logic [5:0]         bone;
      logic signed [6:0]  parent;
      mat_type            m;
   } bone_req_type;

   typedef struct {
      logic [5:0] bone;
      mat_type    m;
   } skin_rsp_type;

   class palette_scoreboard;
      mat_type           rest_mat [64];
      mat_type           off_mat  [64];
      mat_type           glob_mat [64];
      logic signed [6:0] parent_of[64];
      bit                rest_ok  [64];
      bit                off_ok   [64];
      bit                glob_ok  [64];
      skin_rsp_type      skin_q[$];
      int                errors;

      function new();
         for (int i = 0; i < 64; i++) begin
            parent_of[i] = -7'sd1;
            rest_ok[i] = 0;
            off_ok[i] = 0;
            glob_ok[i] = 0;
         end
         errors = 0;
      endfunction

      function bit can_pose(req_kind_type kind, logic [5:0] b);
         logic signed [6:0] p;
         p = parent_of[b];
         if (!off_ok[b]) return 0;
         if (kind == REQ_POSE_REST && !rest_ok[b]) return 0;
         if (p >= 0 && !glob_ok[p[5:0]]) return 0;
         return 1;
      endfunction

      function mat_type mat_mul(mat_type a, mat_type b);
         mat_type c;
         longint  acc, pa, pb;
         for (int r = 0; r < 4; r++) begin
            for (int col = 0; col < 4; col++) begin
               acc = 0;
               for (int k = 0; k < 4; k++) begin
                  pa = longint'($signed(a[r*2 + k/2][32*(k%2) +: 32]));
                  pb = longint'($signed(b[k*2 + col/2][32*(col%2) +: 32]));
                  acc += (pa * pb) >>> 16;
               end
               if (acc > 64'sd2147483647) acc = 64'sd2147483647;
               if (acc < -64'sd2147483648) acc = -64'sd2147483648;
               c[r*2 + col/2][32*(col%2) +: 32] = acc[31:0];
            end
         end
         return c;
      endfunction

      function void note_transfer(bone_req_type it);
         mat_type           loc, g;
         logic signed [6:0] p;
         skin_rsp_type      e;
         case (it.kind)
            REQ_LOAD_REST: begin
               rest_mat[it.bone] = it.m;
               rest_ok[it.bone] = 1;
            end
            REQ_LOAD_OFF: begin
               off_mat[it.bone] = it.m;
               parent_of[it.bone] = it.parent;
               off_ok[it.bone] = 1;
            end
            default: begin
               loc = (it.kind == REQ_POSE) ? it.m : rest_mat[it.bone];
               p = parent_of[it.bone];
               g = (p >= 0) ? mat_mul(glob_mat[p[5:0]], loc) : loc;
               glob_mat[it.bone] = g;
               glob_ok[it.bone] = 1;
               e.bone = it.bone;
               e.m = mat_mul(g, off_mat[it.bone]);
               skin_q = {skin_q, e};
            end
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_result(skin_rsp_type got);
         skin_rsp_type e;
         if (skin_q.size() == 0) begin
            report($sformatf("unexpected result for bone %0d", got.bone));
            return;
         end
         e = skin_q.pop_front();
         if (got.bone !== e.bone)
            report($sformatf("bone got %0d want %0d", got.bone, e.bone));
         for (int i = 0; i < 8; i++)
            if (got.m[i] !== e.m[i])
               report($sformatf("bone %0d pair %0d got %h want %h",
                                e.bone, i, got.m[i], e.m[i]));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_type = '0;
   logic [5:0]  req_bone_index = '0;
   logic [6:0]  req_parent_index = '0;
   mat_type     req_mat = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [5:0]  rsp_out_bone;
   mat_type     rsp_mat;

   palette_scoreboard sb = new();
   int unsigned cycles = 0;
   int          transfers = 0;
   int          rsp_count = 0;

   skeleton_pose_palette_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_bone_index(req_bone_index),
      .req_parent_index(req_parent_index),
      .req_mat_pair_0(req_mat[0]), .req_mat_pair_1(req_mat[1]),
      .req_mat_pair_2(req_mat[2]), .req_mat_pair_3(req_mat[3]),
      .req_mat_pair_4(req_mat[4]), .req_mat_pair_5(req_mat[5]),
      .req_mat_pair_6(req_mat[6]), .req_mat_pair_7(req_mat[7]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_bone(rsp_out_bone),
      .rsp_out_pair_0(rsp_mat[0]), .rsp_out_pair_1(rsp_mat[1]),
      .rsp_out_pair_2(rsp_mat[2]), .rsp_out_pair_3(rsp_mat[3]),
      .rsp_out_pair_4(rsp_mat[4]), .rsp_out_pair_5(rsp_mat[5]),
      .rsp_out_pair_6(rsp_mat[6]), .rsp_out_pair_7(rsp_mat[7])
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("skeleton_pose_palette_top verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      skin_rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.bone = rsp_out_bone;
         got.m = rsp_mat;
         sb.check_result(got);
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3: return 32'h0;
         4: return 32'h00010000;
         default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   function automatic mat_type rand_mat();
      mat_type m;
      for (int i = 0; i < 8; i++) m[i] = {rand_word(), rand_word()};
      return m;
   endfunction

   function automatic mat_type fill_mat(logic [31:0] w);
      mat_type m;
      for (int i = 0; i < 8; i++) m[i] = {w, w};
      return m;
   endfunction

   task automatic send(bone_req_type it);
      int gap;
      if (it.kind inside {REQ_POSE, REQ_POSE_REST} && !sb.can_pose(it.kind, it.bone))
         it.kind = REQ_LOAD_REST;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type <= it.kind;
      req_bone_index <= it.bone;
      req_parent_index <= it.parent;
      req_mat <= it.m;
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_transfer(it);
      transfers++;
   endtask

   task automatic load(req_kind_type k, int b, int p, mat_type m);
      bone_req_type it;
      it.kind = k;
      it.bone = 6'(b);
      it.parent = 7'(p);
      it.m = m;
      send(it);
   endtask

   initial begin
      int           n, base, frames;
      int           p;
      bone_req_type it;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, root, chains, self parent, rest pose, saturation
      load(REQ_LOAD_REST, 0, 0, fill_mat(32'h00010000));
      load(REQ_LOAD_OFF, 0, -1, fill_mat(32'h00010000));
      load(REQ_POSE_REST, 0, 0, '1);
      load(REQ_LOAD_OFF, 1, 0, fill_mat(32'h7fffffff));
      load(REQ_POSE, 1, -64, fill_mat(32'h7fffffff));
      load(REQ_POSE, 1, 63, fill_mat(32'h80000000));
      load(REQ_LOAD_OFF, 63, -64, fill_mat(32'h80000000));
      load(REQ_POSE, 63, 0, '1);
      load(REQ_POSE, 63, 0, '0);
      load(REQ_LOAD_OFF, 63, 63, fill_mat(32'hffffffff));
      load(REQ_POSE, 63, 0, fill_mat(32'h00020000));
      load(REQ_LOAD_REST, 63, 0, '1);
      load(REQ_POSE_REST, 63, 0, '0);
      load(REQ_LOAD_OFF, 2, 1, rand_mat());
      load(REQ_POSE, 2, 0, rand_mat());
      load(REQ_LOAD_OFF, 0, 2, rand_mat());
      load(REQ_POSE, 0, 0, rand_mat());
      load(REQ_LOAD_OFF, 42, 42, rand_mat());
      load(REQ_POSE, 21, 0, rand_mat());

      while (transfers < ITEM_TARGET) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
         base = $urandom_range(0, 64 - n);
         for (int b = 0; b < n; b++) begin
            if ($urandom_range(0, 4) != 0) load(REQ_LOAD_REST, base + b, 0, rand_mat());
            case ($urandom_range(0, 19))
               0, 1, 2: p = -$urandom_range(1, 64);
               3:       p = base + b;
               4:       p = $urandom_range(0, 63);
               default: p = (b == 0) ? -1 : base + $urandom_range(0, b - 1);
            endcase
            load(REQ_LOAD_OFF, base + b, p, rand_mat());
         end
         frames = $urandom_range(1, 4);
         for (int f = 0; f < frames; f++) begin
            for (int b = 0; b < n; b++) begin
               if ($urandom_range(0, 19) == 0) begin
                  it.kind = req_kind_type'($urandom_range(0, 3));
                  it.bone = 6'($urandom_range(0, 63));
                  it.parent = 7'($urandom_range(0, 127));
                  it.m = rand_mat();
                  send(it);
               end
               it.kind = $urandom_range(0, 1) ? REQ_POSE : REQ_POSE_REST;
               it.bone = 6'(base + b);
               it.parent = 7'($urandom_range(0, 127));
               it.m = rand_mat();
               send(it);
            end
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.skin_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("skeleton_pose_palette_top verification clean");
      else
         $display("skeleton_pose_palette_top verification failed");
      $finish;
   end

   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (rsp_count == 150) n = 800;
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         forever begin
            @(posedge clock);
            if (rsp_valid && !rsp_stall) break;
         end
         rsp_count++;
      end
   end

endmodule
